// File: rtl/gpr_pkg.sv
package gpr_pkg;

  localparam int PIN_COUNT_DEF = 16;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [3:0] REG_MODE  = 4'd0;
  localparam logic [3:0] REG_OTYPE = 4'd1;
  localparam logic [3:0] REG_SPEED = 4'd2;
  localparam logic [3:0] REG_PULL  = 4'd3;
  localparam logic [3:0] REG_IDR   = 4'd4;
  localparam logic [3:0] REG_ODR   = 4'd5;
  localparam logic [3:0] REG_BSRR  = 4'd6;
  localparam logic [3:0] REG_LOCK  = 4'd7;
  localparam logic [3:0] REG_AFL   = 4'd8;
  localparam logic [3:0] REG_AFH   = 4'd9;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [15:0] pin_levels;
  } gpr_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] output_levels;
    logic        lock_active;
  } gpr_rsp_t;

  typedef struct packed {
    logic        key_set;
    logic [15:0] locked_pins;
    logic [15:0] candidate;
  } gpr_lock_t;

  // widen one bit per pin to a 2-bit field per pin
  function automatic logic [31:0] spread2(input logic [15:0] pins);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) begin
      m[2*i +: 2] = {2{pins[i]}};
    end
    return m;
  endfunction

  // widen one bit per pin to a 4-bit field per pin, eight pins
  function automatic logic [31:0] spread4(input logic [7:0] pins);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[4*i +: 4] = {4{pins[i]}};
    end
    return m;
  endfunction

endpackage

// File: rtl/gpr_lock.sv
module gpr_lock (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [31:0]       wr_data,
  output gpr_pkg::gpr_lock_t lock_st,
  output logic              key_set_nxt
);
  import gpr_pkg::*;

  localparam logic [1:0] STG_IDLE = 2'd0;
  localparam logic [1:0] STG_ONE  = 2'd1;
  localparam logic [1:0] STG_TWO  = 2'd2;

  logic [1:0]  stage_r, stage_nxt;
  logic        key_set_r;
  logic [15:0] locked_r, locked_nxt;
  logic [15:0] cand_r, cand_nxt;
  logic        key;
  logic [15:0] mask;
  logic        same;

  assign key  = wr_data[16];
  assign mask = wr_data[15:0];
  assign same = (mask == cand_r);

  always_comb begin
    stage_nxt   = stage_r;
    key_set_nxt = key_set_r;
    locked_nxt  = locked_r;
    cand_nxt    = cand_r;
    if (wr_en && !key_set_r) begin
      cand_nxt = mask;
      unique case (stage_r)
        STG_ONE: begin
          if (!key && same) stage_nxt = STG_TWO;
          else              stage_nxt = key ? STG_ONE : STG_IDLE;
        end
        STG_TWO: begin
          if (key && same) begin
            stage_nxt   = STG_IDLE;
            key_set_nxt = 1'b1;
            locked_nxt  = mask;
          end else begin
            stage_nxt = key ? STG_ONE : STG_IDLE;
          end
        end
        default: stage_nxt = key ? STG_ONE : STG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= STG_IDLE;
      key_set_r <= 1'b0;
      locked_r  <= '0;
      cand_r    <= '0;
    end else begin
      stage_r   <= stage_nxt;
      key_set_r <= key_set_nxt;
      locked_r  <= locked_nxt;
      cand_r    <= cand_nxt;
    end
  end

  assign lock_st.key_set     = key_set_r;
  assign lock_st.locked_pins = locked_r;
  assign lock_st.candidate   = cand_r;

endmodule

// File: rtl/gpr_regs.sv
module gpr_regs #(
  parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  gpr_pkg::gpr_req_t  req,
  input  gpr_pkg::gpr_lock_t lock_st,
  output logic [31:0]        read_data,
  output logic [15:0]        out_data_nxt
);
  import gpr_pkg::*;

  localparam logic [16:0] PresentWide = (17'd1 << PIN_COUNT) - 17'd1;
  localparam logic [15:0] PRESENT     = PresentWide[15:0];

  logic [31:0] mode_r, speed_r, pull_r, afl_r, afh_r;
  logic [15:0] otype_r, out_data_r;
  logic [15:0] may;
  logic [31:0] m2, m4l, m4h;
  logic [15:0] set_b, clr_b;
  logic        wr;

  assign wr    = advance && (req.cmd == CMD_WRITE);
  assign may   = PRESENT & ~(lock_st.key_set ? lock_st.locked_pins : 16'h0000);
  assign m2    = spread2(may);
  assign m4l   = spread4(may[7:0]);
  assign m4h   = spread4(may[15:8]);
  assign set_b = req.write_data[15:0] & PRESENT;
  assign clr_b = req.write_data[31:16] & PRESENT;

  always_comb begin
    out_data_nxt = out_data_r;
    if (wr && req.reg_index == REG_ODR) begin
      out_data_nxt = req.write_data[15:0] & PRESENT;
    end else if (wr && req.reg_index == REG_BSRR) begin
      // set wins over clear
      out_data_nxt = (out_data_r & ~clr_b) | set_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= '0;
      otype_r    <= '0;
      speed_r    <= '0;
      pull_r     <= '0;
      afl_r      <= '0;
      afh_r      <= '0;
      out_data_r <= '0;
    end else begin
      out_data_r <= out_data_nxt;
      if (wr) begin
        unique case (req.reg_index)
          REG_MODE:  mode_r  <= (mode_r & ~m2) | (req.write_data & m2);
          REG_OTYPE: otype_r <= (otype_r & ~may) | (req.write_data[15:0] & may);
          REG_SPEED: speed_r <= (speed_r & ~m2) | (req.write_data & m2);
          REG_PULL:  pull_r  <= (pull_r & ~m2) | (req.write_data & m2);
          REG_AFL:   afl_r   <= (afl_r & ~m4l) | (req.write_data & m4l);
          REG_AFH:   afh_r   <= (afh_r & ~m4h) | (req.write_data & m4h);
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    read_data = '0;
    if (req.cmd == CMD_READ) begin
      unique case (req.reg_index)
        REG_MODE:  read_data = mode_r;
        REG_OTYPE: read_data = {16'h0000, otype_r};
        REG_SPEED: read_data = speed_r;
        REG_PULL:  read_data = pull_r;
        REG_IDR:   read_data = {16'h0000, req.pin_levels & PRESENT};
        REG_ODR:   read_data = {16'h0000, out_data_r};
        REG_LOCK:  read_data = {15'h0000, lock_st.key_set, lock_st.candidate};
        REG_AFL:   read_data = afl_r;
        REG_AFH:   read_data = afh_r;
        default:   read_data = '0;
      endcase
    end
  end

endmodule

// File: rtl/gpio_port_registers_unit.sv
// GPIO port register block, sixteen pins.
// Requests enter on the in_ channel (in_valid, in_stall, in_data) as one
// bus access each: a read or write to mode, output type, speed, pull, input
// data, output data, set/reset, lock or the two alternate-function
// registers, together with the pin levels sampled for that access.
// Every request gives exactly one response on the out_ channel (out_valid,
// out_stall, out_data): read data (zero on writes), the output data that
// drives the pins after the access, and the lock flag after the access.
// A request sits in an input register, where the register file is read
// and updated, and its response is captured in an output register; one
// request per cycle is sustained while out_stall is low. The only loop is
// the register state read and written as a request advances out of the
// input register.
// When out_stall holds a response, one more request waits in the input
// register and in_stall rises until the response is taken.
// Reset clears every port register, the lock and the key sequence; no response
// is pending after reset.
module gpio_port_registers_unit #(
  parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gpr_pkg::gpr_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gpr_pkg::gpr_rsp_t out_data
);
  import gpr_pkg::*;

  gpr_req_t    req_r;
  logic        req_valid_r;
  gpr_rsp_t    rsp_r;
  logic        out_valid_r;
  logic        advance;
  logic        accept;
  logic        lock_wr;
  gpr_lock_t   lock_st;
  logic        key_set_nxt;
  logic [31:0] read_data;
  logic [15:0] out_data_nxt;

  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign lock_wr  = advance && (req_r.cmd == CMD_WRITE) && (req_r.reg_index == REG_LOCK);

  gpr_lock u_lock (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (lock_wr),
    .wr_data     (req_r.write_data),
    .lock_st     (lock_st),
    .key_set_nxt (key_set_nxt)
  );

  gpr_regs #(
    .PIN_COUNT (PIN_COUNT)
  ) u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .req          (req_r),
    .lock_st      (lock_st),
    .read_data    (read_data),
    .out_data_nxt (out_data_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept)       req_valid_r <= 1'b1;
      else if (advance) req_valid_r <= 1'b0;
      if (advance)         out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_r <= in_data;
    if (advance) begin
      rsp_r.read_data     <= read_data;
      rsp_r.output_levels <= out_data_nxt;
      rsp_r.lock_active   <= key_set_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = rsp_r;

endmodule
